/* hw/rtl/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// shared types, constants and the month length table for the date advance
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;

    localparam logic [DAY_W-1:0]   DAYS_LONG  = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_FEB   = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_NONE  = 5'd0;
    localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [YEAR_W-1:0]  CENTURY  = 12'd100;
    localparam logic [YEAR_W-1:0]  LAST_YY  = 12'd99;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 12'd4095;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DONE
    } gda_state_t;

    typedef struct packed {
        logic load;
        logic setup_step;
        logic advance;
    } gda_cmd_t;

    typedef struct packed {
        logic setup_done;
        logic count_zero;
        logic month_bad;
    } gda_sts_t;

    // days in a month, zero for a month number with no meaning
    function automatic logic [DAY_W-1:0] month_len(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = DAYS_LONG;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
            MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            default:   len = DAYS_NONE;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/gda_ctrl.sv */
// ----------------------------------------------------------------------------
// gda_ctrl
// sequencer: load, reduce year to its century residue, step days, strobe
// ----------------------------------------------------------------------------
module gda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gda_pkg::gda_sts_t sts,
    output gda_pkg::gda_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    gda_pkg::gda_state_t state_reg;
    gda_pkg::gda_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        busy           = 1'b1;
        done           = 1'b0;
        unique case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = gda_pkg::ST_SETUP;
                end
            end
            gda_pkg::ST_SETUP:
            begin
                // subtract a century per cycle until the residue is below 100
                if (sts.setup_done)
                begin
                    state_next = gda_pkg::ST_RUN;
                end
                else
                begin
                    cmd.setup_step = 1'b1;
                end
            end
            gda_pkg::ST_RUN:
            begin
                if (sts.count_zero || sts.month_bad)
                begin
                    state_next = gda_pkg::ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            gda_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = gda_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/gda_datapath.sv */
// ----------------------------------------------------------------------------
// gda_datapath
// date registers, day counter and running leap year residues
// ----------------------------------------------------------------------------
module gda_datapath #(
    parameter int COUNT_WIDTH = gda_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  gda_pkg::gda_cmd_t            cmd,
    input  logic [gda_pkg::DAY_W-1:0]    start_day,
    input  logic [gda_pkg::MONTH_W-1:0]  start_month,
    input  logic [gda_pkg::YEAR_W-1:0]   start_year,
    input  logic [COUNT_WIDTH-1:0]       day_count,
    output gda_pkg::gda_sts_t            sts,
    output logic [gda_pkg::DAY_W-1:0]    result_day,
    output logic [gda_pkg::MONTH_W-1:0]  result_month,
    output logic [gda_pkg::YEAR_W-1:0]   result_year
);

    logic [gda_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic [gda_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [gda_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [COUNT_WIDTH-1:0]      count_reg, count_next;
    // year mod 100 once setup is over; centuries mod 4 alongside
    logic [gda_pkg::YEAR_W-1:0]  rem_reg,   rem_next;
    logic [1:0]                  cent_reg,  cent_next;

    logic                        leap;
    logic [gda_pkg::DAY_W-1:0]   len;

    assign leap = (year_reg[1:0] == 2'd0) && ((rem_reg != '0) || (cent_reg == 2'd0));
    assign len  = gda_pkg::month_len(month_reg, leap);

    assign sts.setup_done = (rem_reg < gda_pkg::CENTURY);
    assign sts.count_zero = (count_reg == '0);
    assign sts.month_bad  = (len == gda_pkg::DAYS_NONE);

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        cent_next  = cent_reg;
        priority if (cmd.load)
        begin
            day_next   = start_day;
            month_next = start_month;
            year_next  = start_year;
            count_next = day_count;
            rem_next   = start_year;
            cent_next  = 2'd0;
        end
        else if (cmd.setup_step)
        begin
            rem_next  = rem_reg - gda_pkg::CENTURY;
            cent_next = cent_reg + 2'd1;
        end
        else if (cmd.advance)
        begin
            count_next = count_reg - COUNT_WIDTH'(1);
            if (day_reg < len)
            begin
                day_next = day_reg + gda_pkg::DAY_W'(1);
            end
            else
            begin
                day_next = gda_pkg::FIRST_DAY;
                if (month_reg == gda_pkg::MONTH_DEC)
                begin
                    month_next = gda_pkg::MONTH_JAN;
                    year_next  = year_reg + gda_pkg::YEAR_W'(1);
                    // wrap to year 0 restarts both residues
                    if (year_reg == gda_pkg::YEAR_MAX)
                    begin
                        rem_next  = '0;
                        cent_next = 2'd0;
                    end
                    else if (rem_reg == gda_pkg::LAST_YY)
                    begin
                        rem_next  = '0;
                        cent_next = cent_reg + 2'd1;
                    end
                    else
                    begin
                        rem_next = rem_reg + gda_pkg::YEAR_W'(1);
                    end
                end
                else
                begin
                    month_next = month_reg + gda_pkg::MONTH_W'(1);
                end
            end
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        count_reg <= count_next;
        rem_reg   <= rem_next;
        cent_reg  <= cent_next;
    end

    assign result_day   = day_reg;
    assign result_month = month_reg;
    assign result_year  = year_reg;

endmodule

/* hw/rtl/gregorian_date_advance.sv */
// ----------------------------------------------------------------------------
// gregorian_date_advance
// moves a calendar date forward by a count of days, one day per cycle
// ----------------------------------------------------------------------------
//
// channel   handshake              fields
// -------   --------------------   ---------------------------------------------
// request   start, taken if !busy  start_day, start_month, start_year, day_count
// result    done, one-cycle strobe result_day, result_month, result_year
//
// the word is loaded at the edge that takes it; the setup state then strips
// up to 40 centuries off the year to seed the leap year residues and exits
// once the residue is below 100, the day stepping loop steps through the
// days until the count runs out, and then done is raised.
// a month number with no meaning skips the days, so day_count drops out.
// busy stays high throughout and drops in the cycle after done.
// reset clears only the sequencer; the date registers hold whatever they had.
// the receiver cannot stall: the result is valid only while done is high.
//
module gregorian_date_advance #(
    parameter int COUNT_WIDTH = gda_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request word
    input  logic                         start,
    output logic                         busy,
    input  logic [gda_pkg::DAY_W-1:0]    start_day,
    input  logic [gda_pkg::MONTH_W-1:0]  start_month,
    input  logic [gda_pkg::YEAR_W-1:0]   start_year,
    input  logic [COUNT_WIDTH-1:0]       day_count,
    // result word
    output logic                         done,
    output logic [gda_pkg::DAY_W-1:0]    result_day,
    output logic [gda_pkg::MONTH_W-1:0]  result_month,
    output logic [gda_pkg::YEAR_W-1:0]   result_year
);

    // commands from the sequencer, status back from the datapath
    gda_pkg::gda_cmd_t cmd;
    gda_pkg::gda_sts_t sts;

    gda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // a month number with no meaning ends the loop at once, leaving the
    // start date as the result
    gda_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .day_count    (day_count),
        .sts          (sts),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year)
    );

endmodule

/* verif/gregorian_date_advance_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_advance_test
// self-checking bench for the date advance block: directed calendar corners
// and random words go in through the start/busy handshake, and every done
// strobe is compared field by field with a date worked out one day at a time
// by an independent calendar predictor
// ----------------------------------------------------------------------------
module gregorian_date_advance_test;
    import gda_pkg::*;

    localparam int COUNT_W       = COUNT_WIDTH_DEF;
    // limit well above the slowest run of this stimulus
    localparam int CYCLE_LIMIT   = 4_000_000;
    // covers the longest setup, all its century steps plus load and done
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_WORDS  = 76;
    // random words allowed to carry a full width day count
    localparam int MAX_LONG_RUNS = 3;

    // month numbers with no meaning
    localparam logic [MONTH_W-1:0] MONTH_ZERO     = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_PAST_DEC = 4'd13;
    localparam logic [MONTH_W-1:0] MONTH_ALL_ONES = 4'd15;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [DAY_W-1:0]    start_day;
    logic [MONTH_W-1:0]  start_month;
    logic [YEAR_W-1:0]   start_year;
    logic [COUNT_W-1:0]  day_count;
    logic                done;
    logic [DAY_W-1:0]    result_day;
    logic [MONTH_W-1:0]  result_month;
    logic [YEAR_W-1:0]   result_year;

    // dates still owed by the block, oldest first
    date_t       expected_dates[$];
    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned long_runs     = 0;
    int unsigned cycles        = 0;

    gregorian_date_advance #(
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .day_count    (day_count),
        .done         (done),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------------

    // gregorian rule; year 0 passes the divisible by 400 test
    function automatic bit is_leap_year(input logic [YEAR_W-1:0] year);
        int unsigned y;
        y = year;
        return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    // zero for a month number outside january to december
    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        case (month)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: return DAYS_LONG;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
            MONTH_FEB: return is_leap_year(year) ? DAYS_FEB_LEAP : DAYS_FEB;
            default:   return DAYS_NONE;
        endcase
    endfunction

    // walks the date forward one day per count, as the block does
    function automatic date_t advance_date(
        input date_t              from,
        input logic [COUNT_W-1:0] days
    );
        date_t            d;
        logic [DAY_W-1:0] len;
        int unsigned      i;
        d   = from;
        len = days_in_month(d.month, d.year);
        // a meaningless month freezes the date whatever the count
        if (len != DAYS_NONE)
        begin
            for (i = 0; i < days; i++)
            begin
                // day zero simply steps to the first
                if (d.day < len)
                begin
                    d.day = d.day + 1'b1;
                end
                else
                begin
                    // last day, or any day past it, rolls into the next month
                    d.day = FIRST_DAY;
                    if (d.month == MONTH_DEC)
                    begin
                        d.month = MONTH_JAN;
                        // 12-bit year wraps from 4095 to 0 on its own
                        d.year  = d.year + 1'b1;
                    end
                    else
                    begin
                        d.month = d.month + 1'b1;
                    end
                    len = days_in_month(d.month, d.year);
                end
            end
        end
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // drives one request word and waits for the edge that takes it; start is
    // left high so a following word can go out without a bubble
    task automatic send_date(
        input logic [DAY_W-1:0]   day,
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year,
        input logic [COUNT_W-1:0] days
    );
        date_t from;
        from.day   = day;
        from.month = month;
        from.year  = year;
        @(negedge clk);
        start       <= 1'b1;
        start_day   <= day;
        start_month <= month;
        start_year  <= year;
        day_count   <= days;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        expected_dates.push_back(advance_date(from, days));
    endtask

    // start low for a while, with junk on the fields
    task automatic idle_for(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start       <= 1'b0;
            start_day   <= DAY_W'($urandom);
            start_month <= MONTH_W'($urandom);
            start_year  <= YEAR_W'($urandom);
            day_count   <= COUNT_W'($urandom);
        end
    endtask

    // drop start and hold off until every owed date has come back
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // random word, mostly well-formed dates with modest counts, with some
    // odd fields and a few full width counts mixed in
    task automatic send_random_date();
        logic [DAY_W-1:0]   day;
        logic [DAY_W-1:0]   len;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] days;
        int unsigned        pick;

        if ($urandom_range(0, 9) == 0)
            month = MONTH_W'($urandom);
        else
            month = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));

        pick = $urandom_range(0, 7);
        if (pick == 0)
            year = YEAR_W'($urandom);
        else if (pick == 1)
            year = YEAR_W'($urandom_range(4000, 4095));
        else
            year = YEAR_W'($urandom_range(1, 2999));

        // last days are favoured, they carry the rollover logic
        len  = days_in_month(month, year);
        pick = $urandom_range(0, 9);
        if (len == DAYS_NONE || pick == 0)
            day = DAY_W'($urandom);
        else if (pick < 4)
            day = len;
        else
            day = DAY_W'($urandom_range(1, len));

        pick = $urandom_range(0, 99);
        if (pick < 3 && long_runs < MAX_LONG_RUNS)
        begin
            days = COUNT_W'($urandom);
            long_runs++;
        end
        else if (pick < 50)
            days = COUNT_W'($urandom_range(0, 40));
        else if (pick < 85)
            days = COUNT_W'($urandom_range(0, 800));
        else
            days = COUNT_W'($urandom_range(0, 4000));

        send_date(day, month, year, days);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    // done is a single cycle strobe with no back-pressure, so every edge
    // with done high carries one result word
    always @(posedge clk)
    begin : check_result
        date_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch($sformatf("result %0d/%0d/%0d with no word pending",
                                          result_day, result_month, result_year));
            end
            else
            begin
                want = expected_dates.pop_front();
                if (result_day !== want.day)
                    report_mismatch($sformatf("word %0d result_day got %0d want %0d",
                                              words_checked, result_day, want.day));
                if (result_month !== want.month)
                    report_mismatch($sformatf("word %0d result_month got %0d want %0d",
                                              words_checked, result_month, want.month));
                if (result_year !== want.year)
                    report_mismatch($sformatf("word %0d result_year got %0d want %0d",
                                              words_checked, result_year, want.year));
            end
            words_checked++;
        end
    end

    // cycle counter guarding against a hung block
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // count of zero hands back the start date
    task automatic test_zero_count();
        send_date(5'd1, MONTH_JAN, 12'd1, 16'd0);
        send_date(5'd31, MONTH_DEC, 12'd2999, 16'd0);
        wait_for_results();
    endtask

    // 31 and 30 day months roll into the next
    task automatic test_month_ends();
        send_date(5'd31, MONTH_JAN, 12'd2023, 16'd1);
        send_date(5'd30, MONTH_APR, 12'd2023, 16'd1);
        send_date(5'd30, MONTH_SEP, 12'd1999, 16'd1);
        send_date(5'd31, MONTH_JUL, 12'd2023, 16'd1);
        wait_for_results();
    endtask

    // february in ordinary, leap, century and 400-year cases, year 0 too
    task automatic test_leap_years();
        send_date(5'd28, MONTH_FEB, 12'd2024, 16'd1);
        send_date(5'd28, MONTH_FEB, 12'd2023, 16'd1);
        send_date(5'd28, MONTH_FEB, 12'd1900, 16'd1);
        send_date(5'd28, MONTH_FEB, 12'd2000, 16'd1);
        send_date(5'd28, MONTH_FEB, 12'd0, 16'd1);
        send_date(5'd29, MONTH_FEB, 12'd2024, 16'd1);
        wait_for_results();
    endtask

    // new year, and the 12-bit year wrapping from 4095 to 0
    task automatic test_year_rollover();
        send_date(5'd31, MONTH_DEC, 12'd2999, 16'd1);
        send_date(5'd31, MONTH_DEC, 12'd4095, 16'd1);
        send_date(5'd30, MONTH_DEC, 12'd4095, 16'd400);
        wait_for_results();
    endtask

    // day zero, days past the month length, meaningless months
    task automatic test_odd_dates();
        send_date(5'd0, MONTH_MAR, 12'd2021, 16'd1);
        send_date(5'd31, MONTH_APR, 12'd2021, 16'd1);
        send_date(5'd30, MONTH_FEB, 12'd2021, 16'd1);
        send_date(5'd31, MONTH_FEB, 12'd2021, 16'd5);
        send_date(5'd5, MONTH_ZERO, 12'd2021, 16'd1000);
        send_date(5'd31, MONTH_PAST_DEC, 12'd0, 16'd300);
        send_date(5'd0, MONTH_ALL_ONES, 12'd4095, 16'd12);
        wait_for_results();
    endtask

    // full width count, once from the first date and once from the top year
    task automatic test_longest_counts();
        send_date(5'd1, MONTH_JAN, 12'd1, 16'hFFFF);
        send_date(5'd31, MONTH_DEC, 12'd4095, 16'hFFFF);
        wait_for_results();
    endtask

    // bursts of back-to-back words with random gaps, drained once half way
    task automatic test_random_words();
        int unsigned sent;
        int unsigned burst;
        int unsigned k;
        bit          drained;
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 8);
            for (k = 0; k < burst && sent < RANDOM_WORDS; k++)
            begin
                send_random_date();
                sent++;
            end
            if (!drained && sent >= RANDOM_WORDS / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                idle_for($urandom_range(1, 15));
            end
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        start_day   = '0;
        start_month = '0;
        start_year  = '0;
        day_count   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_count();
        test_month_ends();
        test_leap_years();
        test_year_rollover();
        test_odd_dates();
        test_longest_counts();
        test_random_words();

        // let any stray strobe show itself before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_dates.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
